// ===== rtl/tcac_pkg.sv =====
// ----------------------------------------------------------------------------
// tcac_pkg: shared types and constants of the text cell alpha compositor
// Holds the action codes, the cell record and the rounded divide by 255.
// ----------------------------------------------------------------------------
package tcac_pkg;

   localparam logic [1:0] ACT_BLEND    = 2'd0;
   localparam logic [1:0] ACT_STORE    = 2'd1;
   localparam logic [1:0] ACT_READ     = 2'd2;
   // The spare code behaves as a read.
   localparam logic [1:0] ACT_READ_ALT = 2'd3;

   localparam logic [20:0] SPACE_GLYPH = 21'd32;
   localparam logic [7:0]  OPAQUE      = 8'd255;

   typedef struct packed {
      logic [7:0]  bg_red;
      logic [7:0]  bg_green;
      logic [7:0]  bg_blue;
      logic [7:0]  bg_alpha;
      logic [7:0]  fg_red;
      logic [7:0]  fg_green;
      logic [7:0]  fg_blue;
      logic [7:0]  fg_alpha;
      logic [20:0] glyph;
      logic [7:0]  style;
   } cell_type;

   // Queue entry between the front and the back part.
   typedef struct packed {
      logic [1:0]  action;
      logic        in_range;
      cell_type    src;
   } op_type;

   // Rounded division of a 16-bit blend sum by 255: q = (n + 127) / 255.
   // A blend sum is at most 65025, so m = n + 127 stays below 65536, and
   // q = (m + (m >> 8) + 1) >> 8 is exact over that range.
   function automatic logic [7:0] div255(input logic [16:0] n);
      logic [17:0] m;
      logic [17:0] t;
      begin
         m = {1'b0, n} + 18'd127;
         t = m + (m >> 8) + 18'd1;
         div255 = t[15:8];
      end
   endfunction

   // Alpha-over of one component: round((s*a + d*(255-a))/255).
   function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                      input logic [7:0] a);
      logic [16:0] n;
      begin
         n = ({9'd0, s} * {9'd0, a}) + ({9'd0, d} * {9'd0, OPAQUE - a});
         mix = div255(n);
      end
   endfunction

endpackage

// ===== rtl/tcac_front.sv =====
// ----------------------------------------------------------------------------
// tcac_front: input stage and command queue
// Accepts request transactions and queues them for the back.
// ----------------------------------------------------------------------------
module tcac_front #(
   parameter int DEPTH      = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  tcac_pkg::op_type  op_in,
   output logic              op_valid,
   output tcac_pkg::op_type  op_out,
   input  logic              op_take
);
   import tcac_pkg::*;

   localparam int AW = $clog2(DEPTH);

   op_type         q_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           do_push, do_pop;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign op_valid = (cnt_ff != '0);
   assign op_out   = q_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = op_take && op_valid;

   always_comb begin
      wr_in  = do_push ? ((wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ff] <= op_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not grow");
   assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("queue count did not shrink");

endmodule

// ===== rtl/tcac_back.sv =====
// ----------------------------------------------------------------------------
// tcac_back: cell store and blend engine
// Reads the addressed cell, blends or stores, writes back, holds the result until popped.
// ----------------------------------------------------------------------------
module tcac_back #(
   parameter int CELL_COUNT = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 op_valid,
   input  tcac_pkg::op_type     op,
   input  logic [11:0]          op_index,
   output logic                 op_take,
   output logic                 empty,
   input  logic                 pop,
   output tcac_pkg::cell_type   result
);
   import tcac_pkg::*;

   localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam logic [1:0] ST_READ = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   cell_type       mem [CELL_COUNT];
   cell_type       rd_ff;
   cell_type       res_ff, res_in;
   op_type         cur_ff;
   logic [AW-1:0]  adr_ff;
   logic [1:0]     st_ff, st_in;
   logic           wr_en;
   logic [AW-1:0]  adr_now;
   logic [7:0]     fa, ba;
   logic           old_space;

   assign adr_now = AW'(op_index);
   assign op_take = op_valid && (st_ff == ST_READ);
   assign empty   = (st_ff != ST_OUT);
   assign result  = res_ff;
   assign fa      = cur_ff.src.fg_alpha;
   assign ba      = cur_ff.src.bg_alpha;
   assign old_space = (rd_ff.glyph == SPACE_GLYPH);
   assign wr_en   = (st_ff == ST_CALC) && cur_ff.in_range &&
                    (cur_ff.action == ACT_BLEND || cur_ff.action == ACT_STORE);

   always_comb begin
      res_in = rd_ff;
      case (cur_ff.action)
         ACT_STORE: res_in = cur_ff.src;
         ACT_BLEND: begin
            if (fa != 8'd0 || ba != 8'd0) begin
               if (fa == OPAQUE) begin
                  res_in.fg_red   = cur_ff.src.fg_red;
                  res_in.fg_green = cur_ff.src.fg_green;
                  res_in.fg_blue  = cur_ff.src.fg_blue;
                  res_in.fg_alpha = OPAQUE;
               end else if (old_space) begin
                  res_in.fg_red   = mix(cur_ff.src.fg_red, rd_ff.bg_red, fa);
                  res_in.fg_green = mix(cur_ff.src.fg_green, rd_ff.bg_green, fa);
                  res_in.fg_blue  = mix(cur_ff.src.fg_blue, rd_ff.bg_blue, fa);
                  res_in.fg_alpha = OPAQUE;
               end else if (fa != 8'd0) begin
                  res_in.fg_red   = mix(cur_ff.src.fg_red, rd_ff.fg_red, fa);
                  res_in.fg_green = mix(cur_ff.src.fg_green, rd_ff.fg_green, fa);
                  res_in.fg_blue  = mix(cur_ff.src.fg_blue, rd_ff.fg_blue, fa);
                  res_in.fg_alpha = mix(OPAQUE, rd_ff.fg_alpha, fa);
               end
               if (ba == OPAQUE) begin
                  res_in.bg_red   = cur_ff.src.bg_red;
                  res_in.bg_green = cur_ff.src.bg_green;
                  res_in.bg_blue  = cur_ff.src.bg_blue;
                  res_in.bg_alpha = OPAQUE;
               end else if (ba != 8'd0) begin
                  res_in.bg_red   = mix(cur_ff.src.bg_red, rd_ff.bg_red, ba);
                  res_in.bg_green = mix(cur_ff.src.bg_green, rd_ff.bg_green, ba);
                  res_in.bg_blue  = mix(cur_ff.src.bg_blue, rd_ff.bg_blue, ba);
                  res_in.bg_alpha = mix(OPAQUE, rd_ff.bg_alpha, ba);
               end
               if ((old_space && fa != 8'd0) || fa >= res_in.fg_alpha) begin
                  res_in.glyph = cur_ff.src.glyph;
                  res_in.style = cur_ff.src.style;
               end
            end
         end
         default: res_in = rd_ff;
      endcase
      if (!cur_ff.in_range) res_in = '0;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_READ: if (op_valid) st_in = ST_CALC;
         ST_CALC: st_in = ST_OUT;
         ST_OUT:  if (pop) st_in = ST_READ;
         default: st_in = ST_READ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_READ;
      else       st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      if (op_take) begin
         rd_ff  <= mem[adr_now];
         cur_ff <= op;
         adr_ff <= adr_now;
      end
      if (wr_en) mem[adr_ff] <= res_in;
      if (st_ff == ST_CALC) res_ff <= res_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_OUT && !pop) |=> st_ff == ST_OUT && $stable(res_ff))
      else $error("held result changed");
   assert property (@(posedge clock) disable iff (reset)
      op_take |=> st_ff == ST_CALC) else $error("taken op not computed");
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> cur_ff.in_range) else $error("write outside the store");

endmodule

// ===== rtl/text_cell_alpha_compositor_top.sv =====
// ----------------------------------------------------------------------------
// text_cell_alpha_compositor_top: character cell store with alpha blending
// Blends, stores or reads one character cell per request transaction.
// ----------------------------------------------------------------------------
//  Channel   Ports                 Handshake
//  request   req_*                 accepted when push is high and full is low
//  response  rsp_*                 accepted when pop is high and empty is low
//
// Each transaction passes three states in the back part: the store read,
// the blend and write back, and the presentation of the result, which is
// held until popped. The front queue holds four transactions, so requests
// keep arriving while a result stalls.
// Reset clears only the queue pointers and the back state; the cell store
// is left as it is and its contents are undefined until written.
module text_cell_alpha_compositor_top #(
   parameter int CELL_COUNT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_cell_index,
   input  logic [7:0]  req_src_bg_red,
   input  logic [7:0]  req_src_bg_green,
   input  logic [7:0]  req_src_bg_blue,
   input  logic [7:0]  req_src_bg_alpha,
   input  logic [7:0]  req_src_fg_red,
   input  logic [7:0]  req_src_fg_green,
   input  logic [7:0]  req_src_fg_blue,
   input  logic [7:0]  req_src_fg_alpha,
   input  logic [20:0] req_src_glyph,
   input  logic [7:0]  req_src_style,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_bg_red,
   output logic [7:0]  rsp_out_bg_green,
   output logic [7:0]  rsp_out_bg_blue,
   output logic [7:0]  rsp_out_bg_alpha,
   output logic [7:0]  rsp_out_fg_red,
   output logic [7:0]  rsp_out_fg_green,
   output logic [7:0]  rsp_out_fg_blue,
   output logic [7:0]  rsp_out_fg_alpha,
   output logic [20:0] rsp_out_glyph,
   output logic [7:0]  rsp_out_style
);
   import tcac_pkg::*;

   op_type   op_in, op_q;
   logic     op_valid, op_take;
   cell_type res;
   logic [11:0] idx_q;

   // The index travels in the queue entry only as the range flag; the back
   // part needs the address too, so it rides alongside in a second queue.
   op_type   idx_wrap_in, idx_wrap_q;

   always_comb begin
      op_in.action         = req_action;
      op_in.in_range       = ({4'd0, req_cell_index} < 16'(CELL_COUNT)) ||
                             (CELL_COUNT > 4095);
      op_in.src.bg_red     = req_src_bg_red;
      op_in.src.bg_green   = req_src_bg_green;
      op_in.src.bg_blue    = req_src_bg_blue;
      op_in.src.bg_alpha   = req_src_bg_alpha;
      op_in.src.fg_red     = req_src_fg_red;
      op_in.src.fg_green   = req_src_fg_green;
      op_in.src.fg_blue    = req_src_fg_blue;
      op_in.src.fg_alpha   = req_src_fg_alpha;
      op_in.src.glyph      = req_src_glyph;
      op_in.src.style      = req_src_style;
      idx_wrap_in          = '0;
      idx_wrap_in.src.glyph = {9'd0, req_cell_index};
   end

   tcac_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .op_in(op_in), .op_valid(op_valid), .op_out(op_q), .op_take(op_take)
   );

   // Twin queue carrying the addresses, in lock step with the command queue.
   logic idx_full, idx_valid;
   tcac_front u_front_idx (
      .clock(clock), .reset(reset), .push(push && !full), .full(idx_full),
      .op_in(idx_wrap_in), .op_valid(idx_valid), .op_out(idx_wrap_q),
      .op_take(op_take)
   );
   assign idx_q = idx_wrap_q.src.glyph[11:0];

   tcac_back #(.CELL_COUNT(CELL_COUNT)) u_back (
      .clock(clock), .reset(reset), .op_valid(op_valid && idx_valid), .op(op_q),
      .op_index(idx_q), .op_take(op_take), .empty(empty), .pop(pop),
      .result(res)
   );

   assign rsp_out_bg_red   = res.bg_red;
   assign rsp_out_bg_green = res.bg_green;
   assign rsp_out_bg_blue  = res.bg_blue;
   assign rsp_out_bg_alpha = res.bg_alpha;
   assign rsp_out_fg_red   = res.fg_red;
   assign rsp_out_fg_green = res.fg_green;
   assign rsp_out_fg_blue  = res.fg_blue;
   assign rsp_out_fg_alpha = res.fg_alpha;
   assign rsp_out_glyph    = res.glyph;
   assign rsp_out_style    = res.style;

   assert property (@(posedge clock) disable iff (reset)
      idx_full == full) else $error("address queue out of step");
   assert property (@(posedge clock) disable iff (reset)
      idx_valid == op_valid) else $error("address queue out of step");
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> !op_take) else $error("back took work while holding a result");

endmodule

// ===== bench/text_cell_alpha_compositor_top_test.sv =====
// ----------------------------------------------------------------------------
// text_cell_alpha_compositor_top_test: self-checking bench of the compositor
// Drives blend, store and read transactions, predicts every response cell
// with an independent model of the store and checks each one field by field.
// ----------------------------------------------------------------------------
import tcac_pkg::*;

class cell_scoreboard;
   cell_type cells[4096];
   bit       written[4096];
   cell_type pending[$];
   int       errors;

   function automatic logic [7:0] rnd255(input int unsigned n);
      return 8'((n + 127) / 255);
   endfunction

   function automatic logic [7:0] over(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] a);
      return rnd255(s * a + d * (255 - a));
   endfunction

   // Applies one accepted request to the model and queues the response.
   function void note_request(input logic [1:0] act, input logic [11:0] idx,
                              input cell_type src);
      cell_type c;
      logic [7:0] fa, ba;
      bit old_space;
      c = cells[idx];
      if (act == ACT_STORE) begin
         c = src;
      end else if (act == ACT_BLEND) begin
         fa = src.fg_alpha;
         ba = src.bg_alpha;
         if (fa != 0 || ba != 0) begin
            old_space = (c.glyph == SPACE_GLYPH);
            if (fa == OPAQUE) begin
               c.fg_red = src.fg_red; c.fg_green = src.fg_green;
               c.fg_blue = src.fg_blue; c.fg_alpha = OPAQUE;
            end else if (old_space) begin
               c.fg_red   = over(src.fg_red, c.bg_red, fa);
               c.fg_green = over(src.fg_green, c.bg_green, fa);
               c.fg_blue  = over(src.fg_blue, c.bg_blue, fa);
               c.fg_alpha = OPAQUE;
            end else if (fa != 0) begin
               c.fg_red   = over(src.fg_red, c.fg_red, fa);
               c.fg_green = over(src.fg_green, c.fg_green, fa);
               c.fg_blue  = over(src.fg_blue, c.fg_blue, fa);
               c.fg_alpha = over(OPAQUE, c.fg_alpha, fa);
            end
            if (ba == OPAQUE) begin
               c.bg_red = src.bg_red; c.bg_green = src.bg_green;
               c.bg_blue = src.bg_blue; c.bg_alpha = OPAQUE;
            end else if (ba != 0) begin
               c.bg_red   = over(src.bg_red, c.bg_red, ba);
               c.bg_green = over(src.bg_green, c.bg_green, ba);
               c.bg_blue  = over(src.bg_blue, c.bg_blue, ba);
               c.bg_alpha = over(OPAQUE, c.bg_alpha, ba);
            end
            if ((old_space && fa > 0) || fa >= c.fg_alpha) begin
               c.glyph = src.glyph;
               c.style = src.style;
            end
         end
      end
      if (act == ACT_STORE || act == ACT_BLEND) begin
         cells[idx] = c;
         written[idx] = 1;
      end
      pending = {pending, c};
   endfunction

   task report(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task check_response(input cell_type got);
      cell_type w;
      if (pending.size() == 0) begin
         report("response with no request outstanding", 1, 0);
         return;
      end
      w = pending.pop_front();
      if (got.bg_red   !== w.bg_red)   report("bg_red", got.bg_red, w.bg_red);
      if (got.bg_green !== w.bg_green) report("bg_green", got.bg_green, w.bg_green);
      if (got.bg_blue  !== w.bg_blue)  report("bg_blue", got.bg_blue, w.bg_blue);
      if (got.bg_alpha !== w.bg_alpha) report("bg_alpha", got.bg_alpha, w.bg_alpha);
      if (got.fg_red   !== w.fg_red)   report("fg_red", got.fg_red, w.fg_red);
      if (got.fg_green !== w.fg_green) report("fg_green", got.fg_green, w.fg_green);
      if (got.fg_blue  !== w.fg_blue)  report("fg_blue", got.fg_blue, w.fg_blue);
      if (got.fg_alpha !== w.fg_alpha) report("fg_alpha", got.fg_alpha, w.fg_alpha);
      if (got.glyph    !== w.glyph)    report("glyph", got.glyph, w.glyph);
      if (got.style    !== w.style)    report("style", got.style, w.style);
   endtask
endclass

module text_cell_alpha_compositor_top_test;
   logic        clock = 0;
   logic        reset = 1;
   logic        push = 0;
   logic        pop = 0;
   logic        full, empty;
   logic [1:0]  req_action = '0;
   logic [11:0] req_cell_index = '0;
   logic [7:0]  req_src_bg_red = '0, req_src_bg_green = '0, req_src_bg_blue = '0;
   logic [7:0]  req_src_bg_alpha = '0, req_src_fg_red = '0, req_src_fg_green = '0;
   logic [7:0]  req_src_fg_blue = '0, req_src_fg_alpha = '0, req_src_style = '0;
   logic [20:0] req_src_glyph = '0;
   logic [7:0]  rsp_out_bg_red, rsp_out_bg_green, rsp_out_bg_blue, rsp_out_bg_alpha;
   logic [7:0]  rsp_out_fg_red, rsp_out_fg_green, rsp_out_fg_blue, rsp_out_fg_alpha;
   logic [20:0] rsp_out_glyph;
   logic [7:0]  rsp_out_style;

   cell_scoreboard board = new();

   // Idle percentages of the sender and the receiver, changed per phase.
   int unsigned send_idle = 7;
   int unsigned recv_idle = 68;
   // While set, the receiver holds pop low so that the block fills up.
   bit          hold_off = 0;
   int unsigned quiet = 0;
   // Cells the random part may address: a small set, so that most
   // transactions land on cells that have already been written.
   logic [11:0] pool[16];

   text_cell_alpha_compositor_top u_top (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // The receiver: pop is driven at the rising edge, and a response is
   // taken whenever pop and not empty were both high at that edge.
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         board.check_response('{rsp_out_bg_red, rsp_out_bg_green, rsp_out_bg_blue,
                                rsp_out_bg_alpha, rsp_out_fg_red, rsp_out_fg_green,
                                rsp_out_fg_blue, rsp_out_fg_alpha, rsp_out_glyph,
                                rsp_out_style});
      end
      pop <= !reset && !hold_off && ($urandom_range(99) >= recv_idle);
   end

   // Watchdog: counts cycles in which no transaction moves on either side.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offers one request and holds it until the block accepts it. Random
   // idle cycles are inserted before the offer according to the phase.
   task automatic send(input logic [1:0] act, input logic [11:0] idx,
                       input cell_type src);
      while ($urandom_range(99) < send_idle) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1;
      req_action <= act;
      req_cell_index <= idx;
      req_src_bg_red <= src.bg_red;     req_src_bg_green <= src.bg_green;
      req_src_bg_blue <= src.bg_blue;   req_src_bg_alpha <= src.bg_alpha;
      req_src_fg_red <= src.fg_red;     req_src_fg_green <= src.fg_green;
      req_src_fg_blue <= src.fg_blue;   req_src_fg_alpha <= src.fg_alpha;
      req_src_glyph <= src.glyph;       req_src_style <= src.style;
      @(posedge clock);
      while (full) @(posedge clock);
      board.note_request(act, idx, src);
   endtask

   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic cell_type random_cell();
      cell_type c;
      c = cell_type'(93'({$urandom, $urandom, $urandom}));
      c.bg_alpha = pick_alpha();
      c.fg_alpha = pick_alpha();
      case ($urandom_range(3))
         0: c.glyph = SPACE_GLYPH;
         1: c.glyph = 21'($urandom_range(1114111));
         default: ;
      endcase
      return c;
   endfunction

   // Random transactions: reads and blends only ever address cells already
   // written, as the contents of an unwritten cell are undefined.
   task automatic random_run(input int count);
      logic [11:0] idx;
      logic [1:0]  act;
      for (int i = 0; i < count; i++) begin
         idx = pool[$urandom_range(15)];
         if ($urandom_range(19) == 0) idx = 12'($urandom);
         if (!board.written[idx]) act = ACT_STORE;
         else begin
            case ($urandom_range(9))
               0, 1: act = ACT_STORE;
               2:    act = ACT_READ;
               3:    act = ACT_READ_ALT;
               default: act = ACT_BLEND;
            endcase
         end
         send(act, idx, random_cell());
      end
      push <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      cell_type c;
      for (int i = 0; i < 16; i++) pool[i] = 12'($urandom);
      pool[0] = 12'd0;
      pool[1] = 12'd4095;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: extremes, every action and the blend special cases.
      c = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 21'd0, 8'd0};
      send(ACT_STORE, 12'd0, c);
      send(ACT_READ, 12'd0, '1);
      c = '1;
      send(ACT_STORE, 12'd4095, c);
      send(ACT_READ_ALT, 12'd4095, '0);
      // A source with both alphas zero leaves the cell as it is.
      c = '{8'd9, 8'd9, 8'd9, 8'd0, 8'd7, 8'd7, 8'd7, 8'd0, 21'd65, 8'd3};
      send(ACT_BLEND, 12'd4095, c);
      // Opaque copies of both layers.
      c = '{8'd10, 8'd20, 8'd30, 8'd255, 8'd40, 8'd50, 8'd60, 8'd255, 21'd66, 8'd5};
      send(ACT_BLEND, 12'd0, c);
      // A space cell: the foreground blends against the background colour.
      c = '{8'd200, 8'd100, 8'd50, 8'd128, 8'd0, 8'd0, 8'd0, 8'd128, SPACE_GLYPH, 8'd1};
      send(ACT_STORE, 12'd7, c);
      c = '{8'd1, 8'd2, 8'd3, 8'd0, 8'd255, 8'd128, 8'd0, 8'd1, 21'd70, 8'hAA};
      send(ACT_BLEND, 12'd7, c);
      // Partial alphas over a non-space glyph, and a foreground-only source.
      c = '{8'd255, 8'd0, 8'd128, 8'd100, 8'd3, 8'd250, 8'd77, 8'd254, 21'h1FFFFF, 8'h55};
      send(ACT_BLEND, 12'd7, c);
      c = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd90, 8'd90, 8'd90, 8'd1, 21'd33, 8'd0};
      send(ACT_BLEND, 12'd7, c);
      c = '{8'd90, 8'd90, 8'd90, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 21'd33, 8'd0};
      send(ACT_BLEND, 12'd0, c);
      send(ACT_READ, 12'd7, '0);
      push <= 0;
      drain();

      // Pressure: the receiver stops while the sender keeps offering, so the
      // front queue fills and full must hold the request side back.
      hold_off = 1;
      fork
         random_run(30);
         begin
            repeat (200) @(posedge clock);
            hold_off = 0;
         end
      join
      drain();

      random_run(300);
      drain();
      send_idle = 68;
      recv_idle = 7;
      random_run(300);
      drain();
      send_idle = 0;
      recv_idle = 0;
      random_run(300);
      drain();

      if (board.errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/tcac_pkg.sv
rtl/tcac_front.sv
rtl/tcac_back.sv
rtl/text_cell_alpha_compositor_top.sv
bench/text_cell_alpha_compositor_top_test.sv
